/* sv/pht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pht_pkg;

  localparam int NUM_BUCKETS_DEF = 16;
  localparam int BUCKET_WAYS_DEF = 4;

  localparam int REQ_W    = 2;
  localparam int FILE_W   = 16;
  localparam int PAGE_W   = 31;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = 32;

  // in_tdata: file_id, page_number, slot_in
  localparam int IN_DATA_W  = ((FILE_W + PAGE_W + SLOT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SLOT_W + 7) / 8) * 8;

  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [FILE_W-1:0] file;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_READ,
    ST_CMP
  } pht_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic mul;
    logic reduce;
    logic read;
    logic commit;
  } pht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } pht_sts_t;

endpackage

`default_nettype wire

/* sv/page_frame_hash_table.sv */
// page_frame_hash_table: bounded hashed map from (file_id, page_number) to a frame slot
//
// in_*  : one request word per handshake. in_tuser carries the request kind
//         (find, insert, delete); in_tdata carries the key and the slot to insert.
// out_* : one result word per request, in order. out_tuser carries the status
//         (ok, not found, already exists, bucket full); out_tdata the found slot.
// The bucket is (file_id + page_number) mod NUM_BUCKETS, each with BUCKET_WAYS ways.
// A request is accepted in the idle state and its result is loaded into the output
// register from the compare state; no new request is taken before then. In order:
// multiply and reduce states of the reciprocal-multiply hash, read state for bucket
// address correction and memory read, compare state for way compare and write-back.
// After reset a clearing pass empties every bucket; in_tready stays low until it
// finishes.
// The result waits in an output register; the next request is accepted while it
// waits, and its own result is held back in the compare stage while out_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_hash_table #(
  parameter int NUM_BUCKETS = pht_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_WAYS = pht_pkg::BUCKET_WAYS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // file_id[15:0], page_number[46:16], slot_in[54:47], zero fill
  input  wire logic [pht_pkg::IN_DATA_W-1:0] in_tdata,
  // req_type[1:0]
  input  wire logic [pht_pkg::REQ_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // slot_out[7:0]
  output logic [pht_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status[1:0]
  output logic [pht_pkg::STATUS_W-1:0]       out_tuser
);
  import pht_pkg::*;

  pht_cmd_t cmd;
  pht_sts_t sts;

  pht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pht_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BUCKET_WAYS (BUCKET_WAYS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* sv/pht_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pht_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire pht_pkg::pht_sts_t sts,
  output pht_pkg::pht_cmd_t      cmd
);
  import pht_pkg::*;

  pht_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_RED;
      ST_RED:   state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CMP;
      ST_CMP:   if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_RED:  cmd.reduce = 1'b1;
      ST_READ: cmd.read = 1'b1;
      ST_CMP:  cmd.commit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/pht_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module pht_dp #(
  parameter int NUM_BUCKETS = pht_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_WAYS = pht_pkg::BUCKET_WAYS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [pht_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [pht_pkg::REQ_W-1:0]      in_tuser,
  input  wire pht_pkg::pht_cmd_t              cmd,
  output pht_pkg::pht_sts_t                   sts,
  input  wire logic                           out_tready,
  output logic                                out_tvalid,
  output logic [pht_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [pht_pkg::STATUS_W-1:0]        out_tuser
);
  import pht_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  // floor(2^32 / buckets): quotient estimate is low by at most one
  localparam logic [SUM_W:0]   RECIP  = (SUM_W+1)'((65'd1 << SUM_W) / NUM_BUCKETS);
  localparam logic [SUM_W-1:0] NB_SUM = SUM_W'(NUM_BUCKETS);
  localparam logic [BW:0]      NB_REM = (BW+1)'(NUM_BUCKETS);
  localparam logic [BW-1:0]    LAST_B = BW'(NUM_BUCKETS - 1);

  entry_t [BUCKET_WAYS-1:0] mem [NUM_BUCKETS];

  logic [REQ_W-1:0]         req_r;
  logic [FILE_W-1:0]        file_r;
  logic [PAGE_W-1:0]        page_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [SUM_W-1:0]         sum_r;
  logic [SUM_W-1:0]         q_r;
  logic [BW:0]              rem_r;
  logic [BW-1:0]            bucket_r;
  logic [BW-1:0]            bucket_nxt;
  logic [BW-1:0]            clr_cnt_r;
  entry_t [BUCKET_WAYS-1:0] rd_row_r;

  logic [2*SUM_W:0]         prod;
  logic [SUM_W-1:0]         rem_full;

  logic                     hit;
  logic [WW-1:0]            hit_way;
  logic                     free;
  logic [WW-1:0]            free_way;

  entry_t [BUCKET_WAYS-1:0] new_row;
  logic                     row_we;
  logic [STATUS_W-1:0]      res_status;
  logic [SLOT_W-1:0]        res_slot;

  logic                     mem_we;
  logic [BW-1:0]            mem_waddr;
  entry_t [BUCKET_WAYS-1:0] mem_wdata;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [SLOT_W-1:0]        out_slot_r;

  // hashing: sum, reciprocal multiply, remainder, one correction
  assign prod       = sum_r * RECIP;
  assign rem_full   = sum_r - SUM_W'(q_r * NB_SUM);
  assign bucket_nxt = (rem_r >= NB_REM) ? BW'(rem_r - NB_REM) : BW'(rem_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_tuser;
      file_r <= in_tdata[FILE_W-1:0];
      page_r <= in_tdata[FILE_W +: PAGE_W];
      slot_r <= in_tdata[FILE_W+PAGE_W +: SLOT_W];
      sum_r  <= SUM_W'(in_tdata[FILE_W-1:0]) + SUM_W'(in_tdata[FILE_W +: PAGE_W]);
    end
    if (cmd.mul) begin
      q_r <= prod[2*SUM_W-1:SUM_W];
    end
    if (cmd.reduce) begin
      rem_r <= rem_full[BW:0];
    end
    if (cmd.read) begin
      bucket_r <= bucket_nxt;
    end
  end

  // bucket store with registered read
  assign mem_we    = cmd.clear | (cmd.commit & row_we);
  assign mem_waddr = cmd.clear ? clr_cnt_r : bucket_r;
  assign mem_wdata = cmd.clear ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_row_r <= mem[bucket_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // way compare, lowest way wins
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (!hit && rd_row_r[w].valid && rd_row_r[w].file == file_r &&
          rd_row_r[w].page == page_r) begin
        hit     = 1'b1;
        hit_way = WW'(w);
      end
      if (!free && !rd_row_r[w].valid) begin
        free     = 1'b1;
        free_way = WW'(w);
      end
    end
  end

  always_comb begin
    new_row    = rd_row_r;
    row_we     = 1'b0;
    res_status = ST_OK;
    res_slot   = '0;
    unique case (req_r)
      REQ_FIND: begin
        if (hit) begin
          res_slot = rd_row_r[hit_way].slot;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      REQ_INSERT: begin
        if (hit) begin
          res_status = ST_EXISTS;
        end else if (free) begin
          new_row[free_way].valid = 1'b1;
          new_row[free_way].file  = file_r;
          new_row[free_way].page  = page_r;
          new_row[free_way].slot  = slot_r;
          row_we = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      REQ_DELETE: begin
        if (hit) begin
          new_row[hit_way].valid = 1'b0;
          row_we = 1'b1;
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DATA_W'(out_slot_r);
  assign sts        = '{clear_last: (clr_cnt_r == LAST_B),
                        out_free:   (~out_valid_r | out_tready)};

endmodule

`default_nettype wire

/* tb/tb_page_frame_hash_table.sv */
`timescale 1ns / 1ps

module tb_page_frame_hash_table;
  import pht_pkg::*;

  localparam int NB         = NUM_BUCKETS_DEF;
  localparam int WAYS       = BUCKET_WAYS_DEF;
  localparam int ENTRIES    = NB * WAYS;
  localparam int HASH_BITS  = $clog2(NB);
  localparam int FILL_W     = IN_DATA_W - FILE_W - PAGE_W - SLOT_W;
  localparam int KEY_POOL   = 24;
  localparam int RANDOM_REQS = 430;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  // request kind that the block ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [REQ_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // shadow copy of the hash table
  logic              tbl_valid [ENTRIES];
  logic [FILE_W-1:0] tbl_file  [ENTRIES];
  logic [PAGE_W-1:0] tbl_page  [ENTRIES];
  logic [SLOT_W-1:0] tbl_slot  [ENTRIES];

  reply_t pending_replies[$];

  int fail_count;
  int burst_left;
  int req_count [4];
  int status_seen [4];
  int checked_count;

  page_frame_hash_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // works out the reply to one request and updates the shadow table
  function automatic reply_t apply_request(input logic [REQ_W-1:0] req,
                                           input logic [FILE_W-1:0] f,
                                           input logic [PAGE_W-1:0] p,
                                           input logic [SLOT_W-1:0] s);
    reply_t           r;
    logic [SUM_W-1:0] sum;
    int               base;
    int               hit;
    int               w;
    bit               stored;
    r.status = ST_OK;
    r.slot   = '0;
    sum      = SUM_W'(f) + SUM_W'(p);
    base     = int'(sum % NB) * WAYS;
    hit      = -1;
    for (w = 0; w < WAYS; w++) begin
      if (hit < 0 && tbl_valid[base + w] && tbl_file[base + w] == f &&
          tbl_page[base + w] == p)
        hit = w;
    end
    case (req)
      REQ_FIND: begin
        if (hit >= 0) r.slot = tbl_slot[base + hit];
        else r.status = ST_NOT_FOUND;
      end
      REQ_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_EXISTS;
        end else begin
          stored = 1'b0;
          for (w = 0; w < WAYS; w++) begin
            if (!stored && !tbl_valid[base + w]) begin
              tbl_valid[base + w] = 1'b1;
              tbl_file[base + w]  = f;
              tbl_page[base + w]  = p;
              tbl_slot[base + w]  = s;
              stored = 1'b1;
            end
          end
          if (!stored) r.status = ST_FULL;
        end
      end
      REQ_DELETE: begin
        if (hit >= 0) tbl_valid[base + hit] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // random key that lands in one of a few busy buckets
  function automatic void make_key(output logic [FILE_W-1:0] f,
                                   output logic [PAGE_W-1:0] p);
    logic [HASH_BITS-1:0] b;
    b = HASH_BITS'($urandom_range(0, 5) * 3);
    f = FILE_W'($urandom);
    p = PAGE_W'($urandom);
    p[HASH_BITS-1:0] = b - f[HASH_BITS-1:0];
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [FILE_W-1:0] f,
                          input logic [PAGE_W-1:0] p, input logic [SLOT_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{FILL_W{1'b0}}, s, p, f};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pending_replies.push_back(apply_request(req, f, p, s));
    req_count[req]++;
  endtask

  // drop the valid and let every outstanding reply come back
  task automatic wait_table_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_edge_keys();
    send_req(REQ_INSERT, '0, '0, '1);
    send_req(REQ_FIND, '0, '0, '0);
    send_req(REQ_INSERT, '1, '1, '0);
    send_req(REQ_FIND, '1, '1, '1);
    send_req(REQ_FIND, '1, '0, '1);
    send_req(REQ_DELETE, '0, '0, '1);
    send_req(REQ_FIND, '0, '0, '0);
    send_req(REQ_DELETE, '0, '0, '0);
    wait_table_idle();
  endtask

  // five keys that share bucket 5
  task automatic test_bucket_overflow();
    send_req(REQ_INSERT, 16'd5, 31'd0, 8'd11);
    send_req(REQ_INSERT, 16'd4, 31'd1, 8'd22);
    send_req(REQ_INSERT, 16'd0, 31'd5, 8'd33);
    send_req(REQ_INSERT, 16'd1, 31'd4, 8'd44);
    send_req(REQ_INSERT, 16'd2, 31'd3, 8'd55);
    send_req(REQ_INSERT, 16'd4, 31'd1, 8'd99);
    send_req(REQ_FIND, 16'd4, 31'd1, 8'd0);
    send_req(REQ_DELETE, 16'd0, 31'd5, 8'd0);
    send_req(REQ_INSERT, 16'd2, 31'd3, 8'd55);
    send_req(REQ_FIND, 16'd2, 31'd3, 8'd0);
    send_req(REQ_DELETE, 16'd0, 31'd5, 8'd0);
    wait_table_idle();
  endtask

  task automatic test_unused_request();
    send_req(REQ_UNUSED, 16'd1, 31'd4, 8'd200);
    send_req(REQ_UNUSED, '1, '1, '1);
    send_req(REQ_FIND, 16'd1, 31'd4, 8'd0);
    wait_table_idle();
  endtask

  task automatic test_random_traffic();
    logic [FILE_W-1:0] pool_file [KEY_POOL];
    logic [PAGE_W-1:0] pool_page [KEY_POOL];
    logic [FILE_W-1:0] f;
    logic [PAGE_W-1:0] p;
    logic [REQ_W-1:0]  req;
    int                k;
    int                pick;
    int                sent;
    bit                paused;
    for (k = 0; k < KEY_POOL; k++) make_key(pool_file[k], pool_page[k]);
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, KEY_POOL - 1);
      f    = pool_file[k];
      p    = pool_page[k];
      if (pick < 40) req = REQ_INSERT;
      else if (pick < 70) req = REQ_FIND;
      else if (pick < 90) req = REQ_DELETE;
      else if (pick < 95) req = REQ_UNUSED;
      else begin
        // stray key, almost always a miss
        req = REQ_W'($urandom);
        f   = FILE_W'($urandom);
        p   = PAGE_W'($urandom);
      end
      send_req(req, f, p, SLOT_W'($urandom));
      if (req != REQ_UNUSED) sent++;
      if (!paused && sent >= RANDOM_REQS / 2) begin
        wait_table_idle();
        paused = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) make_key(pool_file[k], pool_page[k]);
    end
    wait_table_idle();
  endtask

  // result side: stall pattern and checking
  initial begin : receiver
    int mode;
    int mode_left;
    int run_left;
    logic level;
    out_tready = 1'b0;
    mode_left  = 0;
    run_left   = 0;
    level      = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            level    = ~level;
            run_left = level ? $urandom_range(1, 4) : $urandom_range(1, 12);
          end
          run_left--;
          out_tready <= level;
        end
      endcase
    end
  end

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      status_seen[out_tuser]++;
      checked_count++;
      if (pending_replies.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d", out_tuser, out_tdata);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          fail_count++;
        end
        if (out_tdata[SLOT_W-1:0] !== want.slot) begin
          $error("slot_out: expected %0d, got %0d", want.slot, out_tdata[SLOT_W-1:0]);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("tb_page_frame_hash_table failed");
    $finish;
  end

  initial begin
    int i;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = REQ_FIND;
    fail_count    = 0;
    burst_left    = 0;
    checked_count = 0;
    for (i = 0; i < 4; i++) begin
      req_count[i]   = 0;
      status_seen[i] = 0;
    end
    for (i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_file[i]  = '0;
      tbl_page[i]  = '0;
      tbl_slot[i]  = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_edge_keys();
    test_bucket_overflow();
    test_unused_request();
    test_random_traffic();

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d results never arrived", pending_replies.size());
      fail_count++;
    end

    $display("coverage: %0d finds, %0d inserts, %0d deletes, %0d ignored kinds; %0d words checked",
             req_count[REQ_FIND], req_count[REQ_INSERT], req_count[REQ_DELETE],
             req_count[REQ_UNUSED], checked_count);
    $display("statuses seen: ok %0d, not found %0d, already exists %0d, bucket full %0d",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_EXISTS],
             status_seen[ST_FULL]);
    if (fail_count == 0) begin
      $display("tb_page_frame_hash_table passed");
    end else begin
      $display("tb_page_frame_hash_table failed");
    end
    $finish;
  end

endmodule
